// ===== rtl/stg_pkg.sv =====
// ----------------------------------------------------------------------------
// Sine tone generator package
// Shared widths, register indexes and the quarter-wave sine table builder.
// ----------------------------------------------------------------------------
package stg_pkg;

  localparam int PHASE_BITS        = 32;
  localparam int LOOKUP_PHASE_BITS = 12;
  localparam int SAMPLE_BITS       = 16;
  localparam int COUNT_BITS        = 32;
  localparam int CFG_DATA_BITS     = 32;
  localparam int CFG_INDEX_BITS    = 8;

  localparam int QUARTER_BITS  = LOOKUP_PHASE_BITS - 2;
  localparam int QUARTER_SIZE  = 1 << QUARTER_BITS;
  localparam int ROM_ADDR_BITS = QUARTER_BITS + 1;
  localparam int MAG_BITS      = SAMPLE_BITS - 1;

  localparam logic [63:0] Q62_ONE     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] AMPLITUDE   = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam logic [63:0] QUARTER_MASK = 64'(QUARTER_SIZE) - 64'd1;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_INCREMENT = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_COUNT    = CFG_INDEX_BITS'(1);

  typedef logic [MAG_BITS-1:0] quarter_table_t [QUARTER_SIZE+1];

  // Unsigned 64-bit quotient by restoring long division.
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Magnitude of A*sin(pi/2*q/QUARTER_SIZE), rounded half away from zero.
  // The sine is a 13-term Taylor series in unsigned Q62.
  function automatic quarter_table_t build_quarter_table();
    quarter_table_t tbl;
    logic [63:0]    x;
    logic [63:0]    x2;
    logic [63:0]    term;
    logic [63:0]    sum;
    logic [63:0]    divisor;
    logic [127:0]   prod;
    for (int q = 0; q <= QUARTER_SIZE; q++) begin
      if (q == 0) begin
        sum = 64'd0;
      end else if (q >= QUARTER_SIZE) begin
        sum = Q62_ONE;
      end else begin
        x = (HALF_PI_Q62 >> QUARTER_BITS) * 64'(q) +
            (((HALF_PI_Q62 & QUARTER_MASK) * 64'(q)) >> QUARTER_BITS);
        prod = 128'(x) * 128'(x);
        x2 = prod[125:62];
        term = x;
        sum = x;
        for (int k = 1; k <= 12; k++) begin
          prod = 128'(term) * 128'(x2);
          divisor = 64'((2 * k) * (2 * k + 1));
          term = div_u64(prod[125:62], divisor);
          if ((k % 2) == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
        if (sum > Q62_ONE) begin
          sum = Q62_ONE;
        end
      end
      prod = 128'(sum) * 128'(AMPLITUDE) + (128'd1 << 61);
      tbl[q] = prod[62 +: MAG_BITS];
    end
    return tbl;
  endfunction

endpackage

// ===== rtl/stg_sine_rom.sv =====
// ----------------------------------------------------------------------------
// Sine tone generator quarter-wave ROM
// Holds the sine magnitude for a quarter period, read data registered.
// ----------------------------------------------------------------------------
module stg_sine_rom
  import stg_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic [ROM_ADDR_BITS-1:0] addr,
  output logic [MAG_BITS-1:0]      data
);

  localparam quarter_table_t ROM = build_quarter_table();

  always_ff @(posedge clk) begin
    if (en) begin
      data <= ROM[addr];
    end
  end

endmodule

// ===== rtl/sine_tone_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Sine tone generator
// Direct digital synthesis of a sine tone from a 32-bit phase accumulator.
// ----------------------------------------------------------------------------
// Each item on the input channel is one tick. When the run is not finished it
// yields one item on the output channel: a signed sample and a flag marking
// the final sample of the run. A tick after the run is done gives no result.
// The restart field clears the phase and the sample counter first.
// The configuration channel writes the phase increment (index 0) and the run
// length (index 1); it is always ready and unknown indexes are ignored.
// An accepted tick reaches the output as a sample through the registered
// quarter-wave ROM read and the sign stage after it.
// Throughput is one item per cycle while the receiver takes results.
// When the receiver stalls, the output holds its item and the two-stage
// pipeline fills before in_ready drops.
// Reset sets the phase increment to 42852281, the run length to zero and
// clears the phase, the counter and the pipeline.
// ----------------------------------------------------------------------------
module sine_tone_generator_unit
  import stg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      restart,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SAMPLE_BITS-1:0] sample,
  output logic                      last,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [PHASE_BITS-1:0] phase_increment;
  logic [COUNT_BITS-1:0] sample_count;
  logic [PHASE_BITS-1:0] phase;
  logic [COUNT_BITS-1:0] samples_done;

  logic [PHASE_BITS-1:0]        phase_eff;
  logic [COUNT_BITS-1:0]        done_eff;
  logic                         active;
  logic                         accept;
  logic [LOOKUP_PHASE_BITS-1:0] lookup;
  logic [ROM_ADDR_BITS-1:0]     rom_addr;
  logic [MAG_BITS-1:0]          rom_data;
  logic                         en1;
  logic                         en2;

  logic s1_valid;
  logic s1_neg;
  logic s1_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= PHASE_BITS'(42852281);
      sample_count    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PHASE_INCREMENT: phase_increment <= cfg_data[PHASE_BITS-1:0];
        REG_SAMPLE_COUNT:    sample_count    <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign en2      = !out_valid || out_ready;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;
  assign accept   = in_valid && in_ready;

  assign phase_eff = restart ? '0 : phase;
  assign done_eff  = restart ? '0 : samples_done;
  assign active    = done_eff < sample_count;

  assign lookup   = phase_eff[PHASE_BITS-1 -: LOOKUP_PHASE_BITS];
  assign rom_addr = lookup[QUARTER_BITS] ?
                    ROM_ADDR_BITS'(QUARTER_SIZE) - {1'b0, lookup[QUARTER_BITS-1:0]} :
                    {1'b0, lookup[QUARTER_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      samples_done <= '0;
    end else if (accept) begin
      if (active) begin
        phase        <= phase_eff + phase_increment;
        samples_done <= done_eff + COUNT_BITS'(1);
      end else begin
        phase        <= phase_eff;
        samples_done <= done_eff;
      end
    end
  end

  stg_sine_rom u_rom (
    .clk  (clk),
    .en   (en1),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= accept && active;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_neg  <= lookup[QUARTER_BITS+1];
      s1_last <= (done_eff + COUNT_BITS'(1)) == sample_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sample <= s1_neg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
      last   <= s1_last;
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sine tone generator testbench
// Drives ticks, register writes and output back-pressure at random and checks
// every sample and last flag against an in-bench model of the accumulator,
// the run counter and a fixed-point quarter-wave sine.
// ----------------------------------------------------------------------------
module tb;
  import stg_pkg::*;

  localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED = '1;
  localparam int ITEM_TARGET    = 1400;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  class tone_checker;
    typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   last;
    } tone_t;

    logic [MAG_BITS-1:0]   mag_rom [QUARTER_SIZE+1];
    logic [PHASE_BITS-1:0] step;
    logic [PHASE_BITS-1:0] phase;
    logic [COUNT_BITS-1:0] run_len;
    logic [COUNT_BITS-1:0] played;
    tone_t                 due_samples [$];
    int                    errors;

    function new();
      for (int q = 0; q <= QUARTER_SIZE; q++) begin
        mag_rom[q] = sine_mag(q);
      end
      step    = 32'd42852281;
      run_len = '0;
      phase   = '0;
      played  = '0;
      errors  = 0;
    endfunction

    // Rounded A*sin(pi/2*q/QUARTER_SIZE) from a Q62 Taylor series.
    function logic [MAG_BITS-1:0] sine_mag(int q);
      logic [63:0]  ang;
      logic [63:0]  ang_sq;
      logic [63:0]  term;
      logic [63:0]  acc;
      logic [127:0] prod;
      if (q == 0) begin
        acc = '0;
      end else if (q >= QUARTER_SIZE) begin
        acc = Q62_ONE;
      end else begin
        ang = (HALF_PI_Q62 >> QUARTER_BITS) * 64'(q) +
              ((64'(HALF_PI_Q62[QUARTER_BITS-1:0]) * 64'(q)) >> QUARTER_BITS);
        prod   = {64'd0, ang} * {64'd0, ang};
        ang_sq = prod[125:62];
        term   = ang;
        acc    = ang;
        for (int k = 1; k <= 12; k++) begin
          prod = {64'd0, term} * {64'd0, ang_sq};
          term = prod[125:62] / 64'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            acc = acc - term;
          end else begin
            acc = acc + term;
          end
        end
        if (acc > Q62_ONE) begin
          acc = Q62_ONE;
        end
      end
      prod = {64'd0, acc} * {64'd0, AMPLITUDE} + (128'd1 << 61);
      return prod[62 +: MAG_BITS];
    endfunction

    function void note_write(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_PHASE_INCREMENT: begin
          step = val;
        end
        REG_SAMPLE_COUNT: begin
          run_len = val;
        end
        default: begin
        end
      endcase
    endfunction

    function bit run_over();
      return played >= run_len;
    endfunction

    function int pending();
      return due_samples.size();
    endfunction

    function bit note_tick(logic rs);
      tone_t                        t;
      logic [LOOKUP_PHASE_BITS-1:0] idx;
      logic [MAG_BITS-1:0]          m;
      int                           q;
      if (rs) begin
        phase  = '0;
        played = '0;
      end
      if (played >= run_len) begin
        return 1'b0;
      end
      idx = phase[PHASE_BITS-1 -: LOOKUP_PHASE_BITS];
      q   = int'(idx[QUARTER_BITS-1:0]);
      if (idx[QUARTER_BITS]) begin
        q = QUARTER_SIZE - q;
      end
      m        = mag_rom[q];
      t.sample = idx[QUARTER_BITS+1] ? SAMPLE_BITS'(-{1'b0, m}) : SAMPLE_BITS'({1'b0, m});
      t.last   = (played + 1'b1 == run_len);
      due_samples.push_back(t);
      played = played + 1'b1;
      phase  = phase + step;
      return 1'b1;
    endfunction

    function void check_result(logic [SAMPLE_BITS-1:0] s, logic l);
      tone_t want;
      if (due_samples.size() == 0) begin
        $error("unexpected item: sample %0d last %0b", $signed(s), l);
        errors++;
        return;
      end
      want = due_samples.pop_front();
      if (s !== want.sample) begin
        $error("sample: expected %0d, got %0d", $signed(want.sample), $signed(s));
        errors++;
      end
      if (l !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, l);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic restart;
  logic out_valid;
  logic out_ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic last;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  tone_checker tones;
  int          burst_left = 0;
  int          sample_ticks = 0;
  int          tick_count = 0;
  int          quiet_cycles = 0;
  bit          hold_request = 1'b0;

  sine_tone_generator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .restart   (restart),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tones.check_result(sample, last);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    logic [15:0] pattern;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        for (int i = 0; i < 16; i++) begin
          out_ready <= pattern[i];
          @(posedge clk);
        end
      end
    end
  end

  task automatic tick(input logic rs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (!in_ready);
    tick_count++;
    if (tones.note_tick(rs)) begin
      sample_ticks++;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (tones.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    tones.note_write(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_BITS-1:0] step_val;
    logic [CFG_DATA_BITS-1:0] len_val;
    int                       n_ticks;
    logic                     rs;
    bit                       pressure_done;
    rst       = 1'b1;
    in_valid  = 1'b0;
    restart   = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    pressure_done = 1'b0;
    tones = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With the reset run length of zero no tick gives a sample.
    tick(1'b1);
    tick(1'b0);
    settle();
    write_reg(REG_UNMAPPED, '1);
    write_reg(REG_PHASE_INCREMENT, 32'h4000_0000);
    write_reg(REG_SAMPLE_COUNT, 32'd6);
    repeat (7) tick(1'b0);
    tick(1'b1);
    tick(1'b0);
    settle();
    write_reg(REG_PHASE_INCREMENT, '1);
    write_reg(REG_SAMPLE_COUNT, '1);
    tick(1'b1);
    repeat (3) tick(1'b0);
    settle();
    write_reg(REG_PHASE_INCREMENT, '0);
    tick(1'b0);
    tick(1'b0);
    settle();
    // The run length drops below the samples already played.
    write_reg(REG_SAMPLE_COUNT, 32'd2);
    tick(1'b0);
    tick(1'b1);
    tick(1'b0);
    settle();

    while (tick_count < ITEM_TARGET) begin
      case ($urandom_range(0, 4))
        0: begin
          step_val = $urandom_range(1, 1 << 20);
        end
        1: begin
          step_val = 32'h0010_0000 * $urandom_range(1, 64);
        end
        2: begin
          step_val = '1 - $urandom_range(0, 255);
        end
        default: begin
          step_val = $urandom;
        end
      endcase
      case ($urandom_range(0, 9))
        0: begin
          len_val = '0;
        end
        1: begin
          len_val = '1;
        end
        default: begin
          len_val = $urandom_range(1, 48);
        end
      endcase
      n_ticks = $urandom_range(16, 80);
      if (!pressure_done && sample_ticks >= 300) begin
        len_val       = '1;
        n_ticks       = 60;
        hold_request  = 1'b1;
        pressure_done = 1'b1;
      end
      write_reg(REG_PHASE_INCREMENT, step_val);
      write_reg(REG_SAMPLE_COUNT, len_val);
      for (int i = 0; i < n_ticks; i++) begin
        if (i == 0) begin
          rs = ($urandom_range(0, 3) != 0);
        end else if (tones.run_over()) begin
          rs = ($urandom_range(0, 2) == 0);
        end else begin
          rs = ($urandom_range(0, 24) == 0);
        end
        tick(rs);
      end
      settle();
    end

    if (tones.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/stg_pkg.sv
rtl/stg_sine_rom.sv
rtl/sine_tone_generator_unit.sv
verif/tb.sv
